/* rtl/sqr_pkg.sv */
// shared types and constants for the sequence reorder queue
// no dependencies; imported by sqr_cell, sequence_reorder_queue, reorder_checker and tb

package sqr_pkg;

   localparam int DEPTH       = 16;
   localparam int TAG_WIDTH   = 16;
   localparam int SEQ_WIDTH   = 32;
   localparam int CNT_WIDTH   = $clog2(DEPTH + 1);
   localparam int MAX_WIDTH   = 5;
   localparam int LIM_WIDTH   = (CNT_WIDTH > MAX_WIDTH) ? CNT_WIDTH : MAX_WIDTH;
   localparam int ADDR_WIDTH  = 3;
   localparam int DATA_WIDTH  = 32;

   localparam logic [MAX_WIDTH-1:0] MAX_RESET = MAX_WIDTH'(16);

   typedef enum logic [1:0] {
      OP_PUSH    = 2'd0,
      OP_POP     = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_READY   = 3'd0,
      ST_STALE   = 3'd1,
      ST_QUEUED  = 3'd2,
      ST_DUP     = 3'd3,
      ST_FULL    = 3'd4,
      ST_POPPED  = 3'd5,
      ST_EMPTY   = 3'd6,
      ST_RESTART = 3'd7
   } status_type;

   typedef enum logic {
      REG_START_SEQ   = 1'b0,
      REG_MAX_ENTRIES = 1'b1
   } reg_type;

   typedef struct packed {
      logic [1:0]           operation;
      logic [SEQ_WIDTH-1:0] sequence_number;
      logic [TAG_WIDTH-1:0] payload_tag;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [TAG_WIDTH-1:0] popped_tag;
      logic                 head_ready;
      logic [TAG_WIDTH-1:0] head_tag;
      logic [SEQ_WIDTH-1:0] expected_sequence;
      logic [CNT_WIDTH-1:0] held_count;
   } rsp_type;

   typedef struct packed {
      logic [SEQ_WIDTH-1:0] seq;
      logic [TAG_WIDTH-1:0] tag;
   } entry_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic      push_en;
      logic      pop_en;
   } cell_ctl_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cell_flags_type;

endpackage

/* rtl/sqr_cell.sv */
// one slot of the sorted chain: holds an entry, compares it with the key
// and shifts toward either neighbor; depends on sqr_pkg

module sqr_cell
   import sqr_pkg::*;
(
   input  logic           clock,
   input  cell_ctl_type   cell_ctl,
   input  entry_type      key,
   input  logic           occupied,
   input  logic           left_lt,
   input  entry_type      left_entry,
   input  entry_type      right_entry,
   output entry_type      entry,
   output cell_flags_type flags
);

   entry_type entry_ff;
   entry_type entry_in;

   assign flags.lt = occupied && (entry_ff.seq < key.seq);
   assign flags.eq = occupied && (entry_ff.seq == key.seq);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cell_ctl.push_en) begin
         // smaller entries stay, the insertion point takes the key, the rest move right
         if (!flags.lt) begin
            entry_in = left_lt ? key : left_entry;
         end
      end else if (cell_ctl.pop_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

/* rtl/sequence_reorder_queue.sv */
// top level of the sequence reorder queue: control, csr port, output register
// depends on sqr_pkg and the sqr_cell chain
//
//   channel  direction  handshake              beat
//   req      in         req_valid / req_stall  req_type: operation, sequence, tag
//   rsp      out        rsp_valid / rsp_stall  rsp_type: status, tags, expected, count
//   csr      in         apb psel / penable     start_sequence @0, max_entries @4
//
// one item per cycle while req_stall is low; its result is registered and shows in the cycle after acceptance
// the chain of cells compares all held entries with the key in parallel and shifts
// reset is synchronous and empties the store; no clearing pass
// req_stall rises only while a result is held and rsp_stall is high

module sequence_reorder_queue
   import sqr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_WIDTH-1:0] paddr,
   input  logic [DATA_WIDTH-1:0] pwdata,
   output logic [DATA_WIDTH-1:0] prdata,
   output logic                  pready
);

   logic [SEQ_WIDTH-1:0] start_ff;
   logic [MAX_WIDTH-1:0] max_ff;
   logic [SEQ_WIDTH-1:0] exp_ff,   exp_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff,  rsp_data_in;

   cell_ctl_type   cell_ctl;
   entry_type      cell_key;
   entry_type      cell_q   [DEPTH];
   cell_flags_type cell_flg [DEPTH];
   logic           cell_occ [DEPTH];

   logic       accept;
   logic       csr_write;
   logic       dup_hit;
   logic       full;
   status_type status;
   logic [TAG_WIDTH-1:0] popped;
   entry_type  head_next;

   // csr port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      unique case (reg_type'(paddr[2]))
         REG_START_SEQ:   prdata = start_ff;
         REG_MAX_ENTRIES: prdata = DATA_WIDTH'(max_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         max_ff   <= MAX_RESET;
      end else if (csr_write) begin
         if (reg_type'(paddr[2]) == REG_START_SEQ) begin
            start_ff <= pwdata[SEQ_WIDTH-1:0];
         end else begin
            max_ff <= pwdata[MAX_WIDTH-1:0];
         end
      end
   end

   // cell chain
   assign cell_key.seq = req_data.sequence_number;
   assign cell_key.tag = req_data.payload_tag;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         assign cell_occ[gi] = count_ff > CNT_WIDTH'(gi);
         if (gi == 0) begin : g_first
            sqr_cell u_cell (
               .clock       (clock),
               .cell_ctl    (cell_ctl),
               .key         (cell_key),
               .occupied    (cell_occ[gi]),
               .left_lt     (1'b1),
               .left_entry  (cell_key),
               .right_entry (cell_q[gi+1]),
               .entry       (cell_q[gi]),
               .flags       (cell_flg[gi])
            );
         end else if (gi == DEPTH - 1) begin : g_last
            sqr_cell u_cell (
               .clock       (clock),
               .cell_ctl    (cell_ctl),
               .key         (cell_key),
               .occupied    (cell_occ[gi]),
               .left_lt     (cell_flg[gi-1].lt),
               .left_entry  (cell_q[gi-1]),
               .right_entry (cell_q[gi]),
               .entry       (cell_q[gi]),
               .flags       (cell_flg[gi])
            );
         end else begin : g_mid
            sqr_cell u_cell (
               .clock       (clock),
               .cell_ctl    (cell_ctl),
               .key         (cell_key),
               .occupied    (cell_occ[gi]),
               .left_lt     (cell_flg[gi-1].lt),
               .left_entry  (cell_q[gi-1]),
               .right_entry (cell_q[gi+1]),
               .entry       (cell_q[gi]),
               .flags       (cell_flg[gi])
            );
         end
      end
   endgenerate

   always_comb begin
      dup_hit = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         dup_hit = dup_hit | cell_flg[i].eq;
      end
   end

   assign full = (LIM_WIDTH'(count_ff) >= LIM_WIDTH'(max_ff))
              || (count_ff == CNT_WIDTH'(DEPTH));

   // control
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cell_ctl.push_en  = 1'b0;
      cell_ctl.pop_en   = 1'b0;
      exp_in   = exp_ff;
      count_in = count_ff;
      status   = ST_EMPTY;
      popped   = '0;

      case (req_data.operation)
         OP_PUSH: begin
            if (req_data.sequence_number < exp_ff) begin
               status = ST_STALE;
            end else if (req_data.sequence_number == exp_ff) begin
               status = ST_READY;
               exp_in = exp_ff + SEQ_WIDTH'(1);
            end else if (dup_hit) begin
               status = ST_DUP;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               status           = ST_QUEUED;
               cell_ctl.push_en = accept;
               count_in         = count_ff + CNT_WIDTH'(1);
            end
         end
         OP_POP: begin
            if (cell_occ[0] && (cell_q[0].seq == exp_ff)) begin
               status          = ST_POPPED;
               popped          = cell_q[0].tag;
               cell_ctl.pop_en = accept;
               exp_in          = exp_ff + SEQ_WIDTH'(1);
               count_in        = count_ff - CNT_WIDTH'(1);
            end
         end
         OP_RESTART: begin
            status   = ST_RESTART;
            exp_in   = start_ff;
            count_in = '0;
         end
         default: begin
            status = ST_EMPTY;
         end
      endcase

      // head after this beat
      if (cell_ctl.push_en && !cell_flg[0].lt) begin
         head_next = cell_key;
      end else if (cell_ctl.pop_en) begin
         head_next = cell_q[1];
      end else begin
         head_next = cell_q[0];
      end

      rsp_data_in.status            = status;
      rsp_data_in.popped_tag        = popped;
      rsp_data_in.head_ready        = (count_in != '0) && (head_next.seq == exp_in);
      rsp_data_in.head_tag          = (count_in != '0) ? head_next.tag : '0;
      rsp_data_in.expected_sequence = exp_in;
      rsp_data_in.held_count        = count_in;

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            exp_ff   <= exp_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/sv/reorder_checker.sv */
// checker for the sequence reorder queue: tracks csr writes, predicts each result
// from its own copy of the sorted store and compares beats on the rsp channel
// depends on sqr_pkg
`timescale 1ns / 1ps

module reorder_checker
   import sqr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_WIDTH-1:0] paddr,
   input  logic [DATA_WIDTH-1:0] pwdata,
   input  logic [DATA_WIDTH-1:0] prdata,
   input  logic                  pready,
   output int                    mismatches,
   output int                    owed,
   output logic [SEQ_WIDTH-1:0]  expected_hint
);

   // copy of the registers and of the store
   logic [SEQ_WIDTH-1:0] start_seq;
   logic [MAX_WIDTH-1:0] max_ent;
   logic [SEQ_WIDTH-1:0] held_seq [DEPTH];
   logic [TAG_WIDTH-1:0] held_tag [DEPTH];
   int                   held;
   logic [SEQ_WIDTH-1:0] next_exp;

   rsp_type rsp_due [$];

   initial begin
      mismatches    = 0;
      owed          = 0;
      expected_hint = '0;
   end

   task automatic report_bad(input string what, input logic [63:0] got,
                             input logic [63:0] want);
      if (mismatches < 50)
         $display("%0t reorder_checker: %s got %0h want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic rsp_type next_reorder_result(input req_type beat);
      rsp_type res;
      int      pos;
      int      lim;
      res = '0;
      lim = (max_ent < DEPTH) ? int'(max_ent) : DEPTH;
      case (beat.operation)
         OP_PUSH: begin
            if (beat.sequence_number < next_exp) begin
               res.status = ST_STALE;
            end else if (beat.sequence_number == next_exp) begin
               next_exp   = next_exp + 1'b1;
               res.status = ST_READY;
            end else begin
               pos = 0;
               while (pos < held && held_seq[pos] < beat.sequence_number)
                  pos++;
               if (pos < held && held_seq[pos] == beat.sequence_number) begin
                  res.status = ST_DUP;
               end else if (held >= lim) begin
                  res.status = ST_FULL;
               end else begin
                  for (int i = held; i > pos; i--) begin
                     held_seq[i] = held_seq[i-1];
                     held_tag[i] = held_tag[i-1];
                  end
                  held_seq[pos] = beat.sequence_number;
                  held_tag[pos] = beat.payload_tag;
                  held++;
                  res.status = ST_QUEUED;
               end
            end
         end
         OP_POP: begin
            if (held == 0 || held_seq[0] != next_exp) begin
               res.status = ST_EMPTY;
            end else begin
               res.popped_tag = held_tag[0];
               for (int i = 1; i < held; i++) begin
                  held_seq[i-1] = held_seq[i];
                  held_tag[i-1] = held_tag[i];
               end
               held--;
               next_exp   = next_exp + 1'b1;
               res.status = ST_POPPED;
            end
         end
         OP_RESTART: begin
            held       = 0;
            next_exp   = start_seq;
            res.status = ST_RESTART;
         end
         default: res.status = ST_EMPTY;
      endcase
      if (held > 0) begin
         res.head_ready = (held_seq[0] == next_exp);
         res.head_tag   = held_tag[0];
      end
      res.expected_sequence = next_exp;
      res.held_count        = CNT_WIDTH'(held);
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type              want;
      logic [DATA_WIDTH-1:0] reg_now;
      if (reset) begin
         rsp_due.delete();
         held      = 0;
         next_exp  = '0;
         start_seq = '0;
         max_ent   = MAX_RESET;
      end else begin
         // a result always trails its request
         if (rsp_valid && !rsp_stall) begin
            if (rsp_due.size() == 0) begin
               report_bad("result with none due, status", rsp_data.status, 0);
            end else begin
               want = rsp_due[0];
               rsp_due.delete(0);
               if (rsp_data.status != want.status)
                  report_bad("status", rsp_data.status, want.status);
               if (rsp_data.popped_tag != want.popped_tag)
                  report_bad("popped_tag", rsp_data.popped_tag, want.popped_tag);
               if (rsp_data.head_ready !== want.head_ready)
                  report_bad("head_ready", rsp_data.head_ready, want.head_ready);
               if (rsp_data.head_tag != want.head_tag)
                  report_bad("head_tag", rsp_data.head_tag, want.head_tag);
               if (rsp_data.expected_sequence != want.expected_sequence)
                  report_bad("expected_sequence", rsp_data.expected_sequence,
                             want.expected_sequence);
               if (rsp_data.held_count != want.held_count)
                  report_bad("held_count", rsp_data.held_count, want.held_count);
            end
         end
         if (psel && penable && pready) begin
            case (reg_type'(paddr[2]))
               REG_START_SEQ:   reg_now = start_seq;
               default:         reg_now = DATA_WIDTH'(max_ent);
            endcase
            if (pwrite) begin
               case (reg_type'(paddr[2]))
                  REG_START_SEQ: start_seq = pwdata[SEQ_WIDTH-1:0];
                  default:       max_ent   = pwdata[MAX_WIDTH-1:0];
               endcase
            end else if (prdata !== reg_now) begin
               report_bad("csr read", prdata, reg_now);
            end
         end
         if (req_valid && !req_stall)
            rsp_due.push_back(next_reorder_result(req_data));
      end
      owed          <= rsp_due.size();
      expected_hint <= next_exp;
   end

endmodule

/* tb/sv/tb.sv */
// testbench top for the sequence reorder queue: clock, reset, csr setup, stimulus
// depends on sqr_pkg, sequence_reorder_queue and reorder_checker
`timescale 1ns / 1ps

module tb;
   import sqr_pkg::*;

   localparam logic [1:0]            OP_UNUSED  = 2'd3;
   localparam logic [ADDR_WIDTH-1:0] START_ADDR = ADDR_WIDTH'({REG_START_SEQ, 2'b00});
   localparam logic [ADDR_WIDTH-1:0] MAX_ADDR   = ADDR_WIDTH'({REG_MAX_ENTRIES, 2'b00});
   localparam int                    PHASES     = 8;
   localparam int                    PHASE_BEATS = 115;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [ADDR_WIDTH-1:0] paddr     = '0;
   logic [DATA_WIDTH-1:0] pwdata    = '0;
   logic [DATA_WIDTH-1:0] prdata;
   logic                  pready;

   int                    mismatches;
   int                    owed;
   logic [SEQ_WIDTH-1:0]  expected_hint;

   int                    burst_left  = 0;
   int                    stall_left  = 0;
   int                    stall_mode  = 0;

   sequence_reorder_queue i_dut (.*);

   reorder_checker i_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: free-running, light random or heavy stall stretches
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(10, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 9) < 3);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   task automatic csr_access(input logic wr, input logic [ADDR_WIDTH-1:0] addr,
                             input logic [DATA_WIDTH-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
   endtask

   task automatic program_queue(input logic [SEQ_WIDTH-1:0] start,
                                input logic [MAX_WIDTH-1:0] limit);
      csr_access(1'b1, START_ADDR, start);
      csr_access(1'b1, MAX_ADDR, DATA_WIDTH'(limit));
      csr_access(1'b0, START_ADDR, '0);
      csr_access(1'b0, MAX_ADDR, '0);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic send_beat(input logic [1:0] op, input logic [SEQ_WIDTH-1:0] seq,
                            input logic [TAG_WIDTH-1:0] tag);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= '{operation: op, sequence_number: seq, payload_tag: tag};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   // let every owed result come back before touching the registers
   task automatic drain_queue();
      req_valid <= 1'b0;
      do @(posedge clock); while (owed != 0);
   endtask

   // mostly pushes near the expected number so the store fills, drains and reorders
   task automatic send_random_beat();
      int                   pick;
      logic [SEQ_WIDTH-1:0] seq;
      logic [TAG_WIDTH-1:0] tag;
      pick = $urandom_range(0, 99);
      tag  = $urandom();
      if (pick < 45) begin
         seq = expected_hint +
               (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24));
         send_beat(OP_PUSH, seq, tag);
      end else if (pick < 70) begin
         send_beat(OP_POP, $urandom(), tag);
      end else if (pick < 78) begin
         send_beat(OP_PUSH, expected_hint - $urandom_range(1, 8), tag);
      end else if (pick < 88) begin
         send_beat(OP_PUSH, $urandom(), tag);
      end else if (pick < 93) begin
         send_beat(OP_PUSH, expected_hint + $urandom_range(1, 4), tag);
      end else if (pick < 97) begin
         send_beat(OP_RESTART, $urandom(), tag);
      end else begin
         send_beat(OP_UNUSED, $urandom(), tag);
      end
   endtask

   initial begin
      logic [SEQ_WIDTH-1:0] start;
      logic [MAX_WIDTH-1:0] limit;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: sorted insert, duplicates, full, stale, unmatched pop, unused op
      program_queue(32'hFFFF_FFF0, 5'd3);
      send_beat(OP_RESTART, 32'h0, 16'h0);
      send_beat(OP_POP,     32'h0, 16'h0);
      send_beat(OP_PUSH,    32'hFFFF_FFFF, 16'hFFFF);
      send_beat(OP_PUSH,    32'hFFFF_FFFF, 16'h0000);
      send_beat(OP_PUSH,    32'hFFFF_FFF2, 16'h1234);
      send_beat(OP_PUSH,    32'hFFFF_FFF1, 16'hA5A5);
      send_beat(OP_PUSH,    32'hFFFF_FFF5, 16'h5A5A);
      send_beat(OP_PUSH,    32'hFFFF_FFF2, 16'h0001);
      send_beat(OP_PUSH,    32'h0, 16'h0);
      send_beat(OP_POP,     32'h0, 16'h0);
      send_beat(OP_UNUSED,  32'hFFFF_FFFF, 16'hFFFF);
      send_beat(OP_PUSH,    32'hFFFF_FFF0, 16'h8000);
      send_beat(OP_POP,     32'h0, 16'h0);
      send_beat(OP_POP,     32'h0, 16'h0);
      send_beat(OP_POP,     32'h0, 16'h0);
      drain_queue();

      // limit zero below the held count, then expected number wrap
      program_queue(32'hFFFF_FFFE, 5'd0);
      send_beat(OP_PUSH,    32'hFFFF_FFF8, 16'h0F0F);
      send_beat(OP_PUSH,    32'hFFFF_FFFF, 16'hF0F0);
      send_beat(OP_RESTART, 32'h0, 16'h0);
      send_beat(OP_PUSH,    32'hFFFF_FFFF, 16'h7FFF);
      send_beat(OP_PUSH,    32'hFFFF_FFFE, 16'h0002);
      send_beat(OP_PUSH,    32'hFFFF_FFFF, 16'h0003);
      send_beat(OP_PUSH,    32'h0, 16'h0004);
      send_beat(OP_PUSH,    32'h0, 16'h0005);
      send_beat(OP_POP,     32'h0, 16'h0);
      drain_queue();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       begin start = 32'h0;         limit = 5'd16; end
            1:       begin start = 32'hFFFF_FFF0; limit = 5'd31; end
            2:       begin start = $urandom();    limit = 5'd0;  end
            3:       begin start = $urandom();    limit = 5'd1;  end
            4:       begin start = 32'h7FFF_FFFF; limit = 5'd16; end
            5:       begin start = $urandom();    limit = 5'd4;  end
            6:       begin start = $urandom();    limit = $urandom_range(2, 16); end
            default: begin start = $urandom();    limit = $urandom_range(0, 31); end
         endcase
         program_queue(start, limit);
         // sometimes keep the old store so a lower limit meets a fuller store
         if ($urandom_range(0, 3) != 0)
            send_beat(OP_RESTART, $urandom(), $urandom());
         for (int n = 0; n < PHASE_BEATS; n++)
            send_random_beat();
         drain_queue();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule

/* sim.f */
rtl/sqr_pkg.sv
rtl/sqr_cell.sv
rtl/sequence_reorder_queue.sv
tb/sv/reorder_checker.sv
tb/sv/tb.sv
